@@ sv/heavy_hitter_table_prune_core_assert.svh @@
// assertion macros for the heavy hitter table checker
`ifndef HEAVY_HITTER_TABLE_PRUNE_CORE_ASSERT_SVH
`define HEAVY_HITTER_TABLE_PRUNE_CORE_ASSERT_SVH

// same-cycle implication
`define HHTP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hhtp assertion failed");

// next-cycle implication
`define HHTP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hhtp assertion failed");

`endif

@@ sv/hhtp_pkg.sv @@
package hhtp_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned SumW   = 32;
  localparam int unsigned OwnerW = 48;
  localparam int unsigned ProtoW = 16;
  localparam int unsigned TotalW = 64;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpClose = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [SumW-1:0] sum;
  } entry_t;

  typedef enum logic [10:0] {
    StIdle    = 11'b000_0000_0001,
    StSrchRd  = 11'b000_0000_0010,
    StSrchChk = 11'b000_0000_0100,
    StMiss    = 11'b000_0000_1000,
    StAppend  = 11'b000_0001_0000,
    StSortI   = 11'b000_0010_0000,
    StSortLd  = 11'b000_0100_0000,
    StSortCmp = 11'b000_1000_0000,
    StSortPut = 11'b001_0000_0000,
    StEmitRd  = 11'b010_0000_0000,
    StEmitOut = 11'b100_0000_0000
  } state_e;

endpackage

@@ sv/heavy_hitter_table_prune_core.sv @@
// add: linear search of the table; a hit adds to that entry's sum, a miss appends, plus a sort when full
// sort: insertion sort over the entry memory, highest sum first
// close: sort, then one result per entry, last on the final one; an empty table gives a single empty result
// the entry memory has one write port and one registered read port; results cannot be stalled
// rst_ni clears the control state, entry count and interval total; entries are not cleared
module heavy_hitter_table_prune_core #(
  parameter int unsigned MAX_KEPT = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op_i,
  input  logic [hhtp_pkg::OwnerW-1:0]  owner_id_i,
  input  logic [hhtp_pkg::ProtoW-1:0]  proto_i,
  input  logic [hhtp_pkg::SumW-1:0]    amount_i,
  output logic                         valid_o,
  output logic [hhtp_pkg::OwnerW-1:0]  out_owner_id_o,
  output logic [hhtp_pkg::ProtoW-1:0]  out_proto_o,
  output logic [hhtp_pkg::SumW-1:0]    entry_sum_o,
  output logic [hhtp_pkg::TotalW-1:0]  interval_total_o,
  output logic                         is_empty_o,
  output logic                         last_o
);
  import hhtp_pkg::*;

  localparam int unsigned Depth = 2 * MAX_KEPT + 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [CntW-1:0] KeptC  = CntW'(MAX_KEPT);
  localparam logic [CntW-1:0] OneC   = CntW'(1);
  localparam logic [CntW-1:0] TwoC   = CntW'(2);

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      j_q, j_d;
  logic [TotalW-1:0]    total_q, total_d;
  logic                 close_q, close_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [SumW-1:0]      amt_q, amt_d;
  entry_t               cur_q, cur_d;

  logic                 we;
  logic [CntW-1:0]      waddr, raddr;
  entry_t               wdata, rdata;

  logic                 vld_q, vld_d;
  logic [OwnerW-1:0]    o_owner_q, o_owner_d;
  logic [ProtoW-1:0]    o_proto_q, o_proto_d;
  logic [SumW-1:0]      o_sum_q, o_sum_d;
  logic [TotalW-1:0]    o_total_q, o_total_d;
  logic                 o_empty_q, o_empty_d;
  logic                 o_last_q, o_last_d;

  // entry store
  hhtp_mem #(.Depth(Depth), .AddrW(AddrW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // sequencer: search, append, insertion sort, emit
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    j_d       = j_q;
    total_d   = total_q;
    close_d   = close_q;
    key_d     = key_q;
    amt_d     = amt_q;
    cur_d     = cur_q;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = cur_q;
    raddr     = idx_q;
    vld_d     = 1'b0;
    o_owner_d = o_owner_q;
    o_proto_d = o_proto_q;
    o_sum_d   = o_sum_q;
    o_total_d = o_total_q;
    o_empty_d = o_empty_q;
    o_last_d  = o_last_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          key_d   = {owner_id_i, proto_i};
          amt_d   = amount_i;
          close_d = op_i;
          idx_d   = '0;
          if (op_i == OpAdd) begin
            total_d = total_q + TotalW'(amount_i);
            state_d = (count_q == '0) ? StMiss : StSrchRd;
          end else if (count_q == '0) begin
            vld_d     = 1'b1;
            o_owner_d = '0;
            o_proto_d = '0;
            o_sum_d   = '0;
            o_total_d = total_q;
            o_empty_d = 1'b1;
            o_last_d  = 1'b1;
            total_d   = '0;
          end else begin
            idx_d   = OneC;
            state_d = StSortI;
          end
        end
      end
      StSrchRd: begin
        raddr   = idx_q;
        state_d = StSrchChk;
      end
      StSrchChk: begin
        if (rdata.key == key_q) begin
          we      = 1'b1;
          waddr   = idx_q;
          wdata   = '{key: key_q, sum: rdata.sum + amt_q};
          state_d = StIdle;
        end else begin
          idx_d   = idx_q + OneC;
          state_d = (idx_q + OneC == count_q) ? StMiss : StSrchRd;
        end
      end
      StMiss: begin
        if (count_q == DepthC) begin
          idx_d   = OneC;
          state_d = StSortI;
        end else begin
          state_d = StAppend;
        end
      end
      StAppend: begin
        we      = 1'b1;
        waddr   = count_q;
        wdata   = '{key: key_q, sum: amt_q};
        count_d = count_q + OneC;
        state_d = StIdle;
      end
      StSortI: begin
        if (idx_q >= count_q) begin
          idx_d = '0;
          if (close_q) begin
            state_d = StEmitRd;
          end else begin
            count_d = KeptC;
            state_d = StAppend;
          end
        end else begin
          raddr   = idx_q;
          state_d = StSortLd;
        end
      end
      StSortLd: begin
        cur_d   = rdata;
        j_d     = idx_q;
        raddr   = idx_q - OneC;
        state_d = StSortCmp;
      end
      StSortCmp: begin
        we    = 1'b1;
        waddr = j_q;
        if (rdata.sum < cur_q.sum) begin
          wdata = rdata;
          j_d   = j_q - OneC;
          raddr = j_q - TwoC;
          state_d = (j_q == OneC) ? StSortPut : StSortCmp;
        end else begin
          wdata   = cur_q;
          idx_d   = idx_q + OneC;
          state_d = StSortI;
        end
      end
      StSortPut: begin
        we      = 1'b1;
        waddr   = j_q;
        wdata   = cur_q;
        idx_d   = idx_q + OneC;
        state_d = StSortI;
      end
      StEmitRd: begin
        raddr   = idx_q;
        state_d = StEmitOut;
      end
      StEmitOut: begin
        vld_d     = 1'b1;
        o_owner_d = rdata.key[KeyW-1 -: OwnerW];
        o_proto_d = rdata.key[ProtoW-1:0];
        o_sum_d   = rdata.sum;
        o_total_d = total_q;
        o_empty_d = 1'b0;
        o_last_d  = (idx_q + OneC == count_q);
        if (idx_q + OneC == count_q) begin
          count_d = '0;
          total_d = '0;
          state_d = StIdle;
        end else begin
          idx_d   = idx_q + OneC;
          state_d = StEmitRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      total_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      vld_q   <= vld_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    j_q       <= j_d;
    close_q   <= close_d;
    key_q     <= key_d;
    amt_q     <= amt_d;
    cur_q     <= cur_d;
    o_owner_q <= o_owner_d;
    o_proto_q <= o_proto_d;
    o_sum_q   <= o_sum_d;
    o_total_q <= o_total_d;
    o_empty_q <= o_empty_d;
    o_last_q  <= o_last_d;
  end

  assign busy             = (state_q != StIdle);
  assign valid_o          = vld_q;
  assign out_owner_id_o   = o_owner_q;
  assign out_proto_o      = o_proto_q;
  assign entry_sum_o      = o_sum_q;
  assign interval_total_o = o_total_q;
  assign is_empty_o       = o_empty_q;
  assign last_o           = o_last_q;

endmodule

@@ sv/hhtp_mem.sv @@
module hhtp_mem #(
  parameter int unsigned Depth = 33,
  parameter int unsigned AddrW = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  hhtp_pkg::entry_t      wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output hhtp_pkg::entry_t      rdata_o
);
  import hhtp_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/hhtp_checker.sv @@
`include "heavy_hitter_table_prune_core_assert.svh"

module hhtp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         op_i,
  input logic                         valid_o,
  input logic [hhtp_pkg::OwnerW-1:0]  out_owner_id_o,
  input logic [hhtp_pkg::SumW-1:0]    entry_sum_o,
  input logic                         is_empty_o,
  input logic                         last_o
);
  import hhtp_pkg::*;

  // an add beat never produces a result
  `HHTP_ASSERT_NEXT(a_add_silent, start && !busy && op_i == OpAdd, !valid_o)
  // empty close is a single final beat
  `HHTP_ASSERT_NOW(a_empty_last, valid_o && is_empty_o, last_o)
  // empty close carries zero entry fields
  `HHTP_ASSERT_NOW(a_empty_zero, valid_o && is_empty_o, entry_sum_o == '0 && out_owner_id_o == '0)
  // a non-final beat means more of the run follows
  `HHTP_ASSERT_NOW(a_run_busy, valid_o && !last_o, busy)

endmodule

bind heavy_hitter_table_prune_core hhtp_checker u_hhtp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .op_i           (op_i),
  .valid_o        (valid_o),
  .out_owner_id_o (out_owner_id_o),
  .entry_sum_o    (entry_sum_o),
  .is_empty_o     (is_empty_o),
  .last_o         (last_o)
);

@@ tb/heavy_hitter_table_prune_core_tb.sv @@
`timescale 1ns / 1ps

module heavy_hitter_table_prune_core_tb;
  import hhtp_pkg::*;

  localparam int unsigned MaxKept   = 16;
  localparam int unsigned Depth     = 2 * MaxKept + 1;
  localparam int unsigned IdleLimit = 40000;

  // one input beat
  typedef struct {
    logic              op;
    logic [OwnerW-1:0] owner;
    logic [ProtoW-1:0] proto;
    logic [SumW-1:0]   amount;
    bit                hold;
  } hit_t;

  // one emitted table row
  typedef struct {
    logic [OwnerW-1:0] owner;
    logic [ProtoW-1:0] proto;
    logic [SumW-1:0]   sum;
    logic [TotalW-1:0] total;
    logic              empty;
    logic              last;
  } row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              op_i;
  logic [OwnerW-1:0] owner_id_i;
  logic [ProtoW-1:0] proto_i;
  logic [SumW-1:0]   amount_i;
  logic              valid_o;
  logic [OwnerW-1:0] out_owner_id_o;
  logic [ProtoW-1:0] out_proto_o;
  logic [SumW-1:0]   entry_sum_o;
  logic [TotalW-1:0] interval_total_o;
  logic              is_empty_o;
  logic              last_o;

  heavy_hitter_table_prune_core #(.MAX_KEPT(MaxKept)) dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .owner_id_i, .proto_i, .amount_i,
    .valid_o, .out_owner_id_o, .out_proto_o, .entry_sum_o, .interval_total_o,
    .is_empty_o, .last_o
  );

  hit_t pending_hits[$];
  row_t rows_due[$];
  int   err_cnt;
  int   taken_cnt;
  int   issued_cnt;
  int   idle_cycles;

  // shadow of the hitter table
  logic [KeyW-1:0]   tbl_key [Depth];
  logic [SumW-1:0]   tbl_sum [Depth];
  int unsigned       tbl_cnt;
  logic [TotalW-1:0] tbl_total;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    err_cnt++;
  endtask

  // stable insertion sort, highest sum first
  task automatic rank_table();
    logic [KeyW-1:0] k;
    logic [SumW-1:0] s;
    int j;
    for (int i = 1; i < tbl_cnt; i++) begin
      k = tbl_key[i];
      s = tbl_sum[i];
      j = i;
      while (j > 0 && tbl_sum[j-1] < s) begin
        tbl_key[j] = tbl_key[j-1];
        tbl_sum[j] = tbl_sum[j-1];
        j--;
      end
      tbl_key[j] = k;
      tbl_sum[j] = s;
    end
  endtask

  // apply one accepted beat to the shadow table and queue the rows it emits
  task automatic account_hit(input logic op, input logic [OwnerW-1:0] owner,
                             input logic [ProtoW-1:0] proto, input logic [SumW-1:0] amount);
    logic [KeyW-1:0] key;
    int pos;
    row_t r;
    key = {owner, proto};
    if (op == OpAdd) begin
      pos = tbl_cnt;
      for (int i = 0; i < tbl_cnt; i++)
        if (tbl_key[i] == key) begin
          pos = i;
          break;
        end
      if (pos == tbl_cnt) begin
        if (tbl_cnt > 2 * MaxKept) begin
          rank_table();
          tbl_cnt = MaxKept;
        end
        pos = tbl_cnt;
        tbl_cnt++;
        tbl_key[pos] = key;
        tbl_sum[pos] = '0;
      end
      tbl_sum[pos] = tbl_sum[pos] + amount;
      tbl_total = tbl_total + TotalW'(amount);
    end else begin
      if (tbl_cnt == 0) begin
        r = '{owner: '0, proto: '0, sum: '0, total: tbl_total, empty: 1'b1, last: 1'b1};
        rows_due.push_back(r);
      end else begin
        rank_table();
        for (int i = 0; i < tbl_cnt; i++) begin
          r.owner = tbl_key[i][KeyW-1:ProtoW];
          r.proto = tbl_key[i][ProtoW-1:0];
          r.sum   = tbl_sum[i];
          r.total = tbl_total;
          r.empty = 1'b0;
          r.last  = (i + 1 == tbl_cnt);
          rows_due.push_back(r);
        end
      end
      tbl_cnt   = 0;
      tbl_total = '0;
    end
  endtask

  // monitor: accept beats, check rows, watchdog
  always @(posedge clk_i) begin
    row_t r;
    if (rst_ni) begin
      if (start && !busy) begin
        account_hit(op_i, owner_id_i, proto_i, amount_i);
        taken_cnt <= taken_cnt + 1;
      end
      if (valid_o) begin
        if (rows_due.size() == 0) begin
          report("row emitted with none expected");
        end else begin
          r = rows_due.pop_front();
          if (out_owner_id_o !== r.owner)
            report($sformatf("owner got %h want %h", out_owner_id_o, r.owner));
          if (out_proto_o !== r.proto)
            report($sformatf("proto got %h want %h", out_proto_o, r.proto));
          if (entry_sum_o !== r.sum)
            report($sformatf("sum got %h want %h", entry_sum_o, r.sum));
          if (interval_total_o !== r.total)
            report($sformatf("total got %h want %h", interval_total_o, r.total));
          if (is_empty_o !== r.empty)
            report($sformatf("is_empty got %b want %b", is_empty_o, r.empty));
          if (last_o !== r.last)
            report($sformatf("last got %b want %b", last_o, r.last));
        end
      end
      if ((start && !busy) || valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // driver: one beat at a time, random gap after each accepted beat
  int gap_left;
  bit no_gaps;
  always @(negedge clk_i) begin
    logic nxt_start;
    hit_t h;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && taken_cnt == issued_cnt) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_hits.size() != 0 &&
                     !(pending_hits[0].hold && rows_due.size() != 0)) begin
          h = pending_hits.pop_front();
          op_i       <= h.op;
          owner_id_i <= h.owner;
          proto_i    <= h.proto;
          amount_i   <= h.amount;
          nxt_start  = 1'b1;
          issued_cnt++;
          if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
          gap_left = no_gaps ? 0 : $urandom_range(0, 8);
        end
      end
      start <= nxt_start;
    end
  end

  function automatic hit_t add_hit(input logic [OwnerW-1:0] owner,
                                   input logic [ProtoW-1:0] proto,
                                   input logic [SumW-1:0] amount);
    hit_t h;
    h = '{op: OpAdd, owner: owner, proto: proto, amount: amount, hold: 1'b0};
    return h;
  endfunction

  function automatic hit_t close_hit();
    hit_t h;
    h = '{op: OpClose, owner: OwnerW'({$urandom, $urandom}), proto: ProtoW'($urandom),
          amount: $urandom, hold: 1'b0};
    return h;
  endfunction

  function automatic logic [SumW-1:0] rand_amount();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 2);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [KeyW-1:0] pool[40];
    int pool_n;
    int run_len;
    int total;
    hit_t h;
    start      = 1'b0;
    op_i       = OpAdd;
    owner_id_i = '0;
    proto_i    = '0;
    amount_i   = '0;
    err_cnt    = 0;
    taken_cnt  = 0;
    issued_cnt = 0;
    idle_cycles = 0;
    gap_left   = 0;
    no_gaps    = 1'b0;
    tbl_cnt    = 0;
    tbl_total  = '0;
    rst_ni     = 1'b0;

    // directed: empty close, field extremes, sum wrap, tie order
    pending_hits.push_back(close_hit());
    pending_hits.push_back(add_hit('0, '0, '0));
    pending_hits.push_back(add_hit('1, '1, 32'hFFFF_FFFF));
    pending_hits.push_back(add_hit('1, '1, 32'h0000_0002));
    pending_hits.push_back(add_hit(48'h1, 16'h2, 32'd5));
    pending_hits.push_back(add_hit(48'h2, 16'h1, 32'd5));
    pending_hits.push_back(add_hit('0, 16'hFFFF, 32'd7));
    pending_hits.push_back(close_hit());
    // empty close carrying zero total, right after a close cleared the table
    pending_hits.push_back(close_hit());
    // fill to full capacity and force a prune with ties
    for (int i = 0; i < 34; i++)
      pending_hits.push_back(add_hit(48'(i * 3), 16'(i), 32'(i % 5)));
    h = close_hit();
    h.hold = 1'b1;
    pending_hits.push_back(h);
    total = pending_hits.size();

    // random intervals over a key pool, some wide enough to prune
    while (total < 270) begin
      pool_n = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
      for (int i = 0; i < pool_n; i++) pool[i] = {$urandom, $urandom};
      run_len = $urandom_range(0, 50);
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(0, 19) == 0)
          pending_hits.push_back(add_hit(OwnerW'({$urandom, $urandom}), ProtoW'($urandom),
                                         rand_amount()));
        else begin
          h = add_hit('0, '0, rand_amount());
          {h.owner, h.proto} = pool[$urandom_range(0, pool_n - 1)];
          pending_hits.push_back(h);
        end
      end
      h = close_hit();
      h.hold = ($urandom_range(0, 4) == 0);
      pending_hits.push_back(h);
      total += run_len + 1;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_hits.size() == 0 && taken_cnt == issued_cnt);
    wait (rows_due.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && rows_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
